FILE: sv/bnv_pkg.sv
// Shared types, constants and arithmetic helpers of the BGRA to NV12 converter.
// No dependencies; every other file but bnv_line_ram imports this package.

package bnv_pkg;

    // Frame geometry limits and derived widths
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int SLOT_W      = $clog2(LINE_DEPTH);

    // Configuration port
    localparam int CFG_W       = 13;
    localparam int CFG_ADDR_W  = 1;
    localparam int CMP_W       = CFG_W + 1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } cfg_reg_t;

    // Stream payload widths
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 2;

    // Chroma line store: U sum in the low lane, V sum in the high lane
    localparam int LANE_W      = 9;
    localparam int LINE_W      = 2 * LANE_W;

    // Result kinds carried in tuser bit 0
    localparam logic KIND_LUMA   = 1'b0;
    localparam logic KIND_CHROMA = 1'b1;

    // BT.601 limited-range coefficients
    localparam logic signed [17:0] COEF_YR = 18'sd66;
    localparam logic signed [17:0] COEF_YG = 18'sd129;
    localparam logic signed [17:0] COEF_YB = 18'sd25;
    localparam logic signed [17:0] COEF_UR = -18'sd38;
    localparam logic signed [17:0] COEF_UG = -18'sd74;
    localparam logic signed [17:0] COEF_UB = 18'sd112;
    localparam logic signed [17:0] COEF_VR = 18'sd112;
    localparam logic signed [17:0] COEF_VG = -18'sd94;
    localparam logic signed [17:0] COEF_VB = -18'sd18;
    localparam logic signed [17:0] ROUND_HALF  = 18'sd128;
    localparam logic signed [10:0] LUMA_BASE   = 11'sd16;
    localparam logic signed [10:0] CHROMA_BASE = 11'sd128;

    // Per-pixel position flags that travel with the pixel
    typedef struct packed {
        logic              odd_col;
        logic              odd_row;
        logic              frame_end;
        logic [SLOT_W-1:0] slot;
    } pix_ctl_t;

    // Effective frame size: low bit dropped, clamped to 2..maxv
    function automatic logic [CMP_W-1:0] eff_size(input logic [CFG_W-1:0] reg_val,
                                                  input int maxv);
        logic [CMP_W-1:0] v;
        v = {1'b0, reg_val[CFG_W-1:1], 1'b0};
        if (v < CMP_W'(2))
            v = CMP_W'(2);
        if (v > CMP_W'(maxv))
            v = CMP_W'(maxv);
        return v;
    endfunction

    // floor((x + 128) / 256) + base, clamped to a byte
    function automatic logic [7:0] scale_add(input logic signed [17:0] x,
                                             input logic signed [10:0] base);
        logic signed [17:0] t;
        logic signed [10:0] q;
        t = x + ROUND_HALF;
        q = 11'(t >>> 8);
        q = q + base;
        if (q < 11'sd0)
            return 8'd0;
        else if (q > 11'sd255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

endpackage

FILE: sv/bnv_line_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No dependencies; holds the per-column-pair chroma sums of the converter.

module bnv_line_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] line_mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/bnv_input_stage.sv
// Input stage: configuration registers, raster position tracking and the
// first pipeline register of the pixel. Depends on bnv_pkg.

module bnv_input_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bnv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bnv_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bnv_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s1_adv,
    output logic                          s1_valid,
    output logic [bnv_pkg::IN_DATA_W-1:0] s1_pix,
    output bnv_pkg::pix_ctl_t             s1_ctl
);

    import bnv_pkg::*;

    logic [CFG_W-1:0]     frame_width_reg;
    logic [CFG_W-1:0]     frame_height_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_next;
    logic                 s1_valid_reg;
    logic [IN_DATA_W-1:0] s1_pix_reg;
    pix_ctl_t             s1_ctl_reg;
    pix_ctl_t             ctl_next;

    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] eff_h;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;
    logic             row_end;
    logic             frame_end;
    logic             accept;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Row and frame end detection for the pixel being accepted
    always_comb
    begin
        eff_w     = eff_size(frame_width_reg, MAX_WIDTH);
        eff_h     = eff_size(frame_height_reg, MAX_HEIGHT);
        col_inc   = CMP_W'(col_reg) + CMP_W'(1);
        row_inc   = CMP_W'(row_reg) + CMP_W'(1);
        row_end   = (col_inc >= eff_w);
        frame_end = row_end && (row_inc >= eff_h);

        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end

        ctl_next.odd_col   = col_reg[0];
        ctl_next.odd_row   = row_reg[0];
        ctl_next.frame_end = frame_end;
        ctl_next.slot      = col_reg[COL_W-1:1];
    end

    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Position counters and stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= s_tdata;
            s1_ctl_reg <= ctl_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pix   = s1_pix_reg;
    assign s1_ctl   = s1_ctl_reg;

endmodule

FILE: sv/bnv_csc.sv
// Color space conversion: BT.601 limited-range Y, U and V of one pixel from
// its blue, green and red bytes, by constant multiplies. Depends on bnv_pkg.

module bnv_csc (
    input  logic [bnv_pkg::IN_DATA_W-1:0] pix,
    output logic [7:0]                    luma,
    output logic [7:0]                    cb,
    output logic [7:0]                    cr
);

    import bnv_pkg::*;

    logic signed [17:0] bs;
    logic signed [17:0] gs;
    logic signed [17:0] rs;
    logic signed [17:0] y_sum;
    logic signed [17:0] u_sum;
    logic signed [17:0] v_sum;

    // Components widened to signed operands
    assign bs = signed'({10'd0, pix[7:0]});
    assign gs = signed'({10'd0, pix[15:8]});
    assign rs = signed'({10'd0, pix[23:16]});

    // Weighted sums
    assign y_sum = COEF_YR * rs + COEF_YG * gs + COEF_YB * bs;
    assign u_sum = COEF_UR * rs + COEF_UG * gs + COEF_UB * bs;
    assign v_sum = COEF_VR * rs + COEF_VG * gs + COEF_VB * bs;

    // Round, offset and clamp
    assign luma = scale_add(y_sum, LUMA_BASE);
    assign cb   = scale_add(u_sum, CHROMA_BASE);
    assign cr   = scale_add(v_sum, CHROMA_BASE);

endmodule

FILE: sv/bnv_chroma_out.sv
// Second pipeline stage and output register: chroma pair accumulation against
// the line store and sequencing of one or two results per pixel. Depends on bnv_pkg.

module bnv_chroma_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s1_valid,
    input  bnv_pkg::pix_ctl_t                s1_ctl,
    input  logic [7:0]                       s1_luma,
    input  logic [7:0]                       s1_cb,
    input  logic [7:0]                       s1_cr,
    output logic                             s1_adv,
    input  logic [bnv_pkg::LINE_W-1:0]       line_rd_data,
    output logic                             line_wr_en,
    output logic [bnv_pkg::SLOT_W-1:0]       line_wr_addr,
    output logic [bnv_pkg::LINE_W-1:0]       line_wr_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bnv_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    output logic [bnv_pkg::OUT_USER_W-1:0]   m_tuser
);

    import bnv_pkg::*;

    logic                  s2_valid_reg;
    pix_ctl_t              s2_ctl_reg;
    logic [7:0]            s2_y_reg;
    logic [7:0]            s2_u_reg;
    logic [7:0]            s2_v_reg;
    logic                  phase_reg;
    logic [7:0]            held_u_reg;
    logic [7:0]            held_v_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    logic                  two_results;
    logic                  out_free;
    logic                  emit;
    logic                  done;
    logic                  s2_free;
    logic [9:0]            sum_u;
    logic [9:0]            sum_v;
    logic [LANE_W-1:0]     pair_u;
    logic [LANE_W-1:0]     pair_v;
    logic [OUT_DATA_W-1:0] res_data;
    logic                  res_last;
    logic [OUT_USER_W-1:0] res_user;

    // Flow control: a pixel on an odd row and odd column needs two output slots
    assign two_results = s2_ctl_reg.odd_col && s2_ctl_reg.odd_row;
    assign out_free    = !out_valid_reg || m_tready;
    assign emit        = s2_valid_reg && out_free;
    assign done        = emit && (!two_results || phase_reg);
    assign s2_free     = !s2_valid_reg || done;
    assign s1_adv      = s1_valid && s2_free;

    // 2x2 block average; the line entry was read as the pixel entered this stage.
    // The entry read on an odd row was written at least two pixels earlier, so
    // the write has always landed before the read.
    assign sum_u = 10'(line_rd_data[LANE_W-1:0]) + 10'(held_u_reg) + 10'(s2_u_reg) + 10'd2;
    assign sum_v = 10'(line_rd_data[LINE_W-1:LANE_W]) + 10'(held_v_reg) + 10'(s2_v_reg)
                 + 10'd2;

    // Even-row pair sums for the line store
    assign pair_u = LANE_W'(held_u_reg) + LANE_W'(s2_u_reg);
    assign pair_v = LANE_W'(held_v_reg) + LANE_W'(s2_v_reg);

    assign line_wr_en   = done && s2_ctl_reg.odd_col && !s2_ctl_reg.odd_row;
    assign line_wr_addr = s2_ctl_reg.slot;
    assign line_wr_data = {pair_v, pair_u};

    // Result selection: luma first, then the chroma pair
    always_comb
    begin
        if (phase_reg)
        begin
            res_data = {sum_v[9:2], sum_u[9:2]};
            res_last = 1'b1;
            res_user = {s2_ctl_reg.frame_end, KIND_CHROMA};
        end
        else
        begin
            res_data = {8'd0, s2_y_reg};
            res_last = !two_results;
            res_user = {s2_ctl_reg.frame_end && !two_results, KIND_LUMA};
        end
    end

    // Stage 2 control and held chroma of the even column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            held_u_reg   <= '0;
            held_v_reg   <= '0;
        end
        else
        begin
            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (done)
                s2_valid_reg <= 1'b0;

            if (done)
                phase_reg <= 1'b0;
            else if (emit && two_results)
                phase_reg <= 1'b1;

            if (done && !s2_ctl_reg.odd_col)
            begin
                held_u_reg <= s2_u_reg;
                held_v_reg <= s2_v_reg;
            end
        end
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_ctl_reg <= s1_ctl;
            s2_y_reg   <= s1_luma;
            s2_u_reg   <= s1_cb;
            s2_v_reg   <= s1_cr;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= res_data;
            out_last_reg <= res_last;
            out_user_reg <= res_user;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: sv/bgra_to_nv12_converter_core.sv
// Top level of the BGRA to NV12 converter: input stage, color conversion, chroma
// line store and output sequencer. Depends on bnv_pkg and bnv_ datapath modules.

// Converts a raster stream of BGR pixels of an even-sized frame into BT.601
// limited-range luma and 4:2:0 chroma, interleaved on one output stream: every
// pixel gives a luma transaction, and every odd-column pixel of an odd row is
// followed by the U,V pair of its 2x2 block (tlast marks the final transaction
// of a pixel, tuser bit 1 the final transaction of the frame). With the downstream
// ready, a pixel can be taken every cycle, but a pixel with two results holds the
// input while its chroma pair is sent; the single output register limits
// throughput to one transaction per cycle. The first transaction of a pixel
// passes the input register, the stage 2 register and the output register. The
// line store (MAX_WIDTH/2 entries of two 9-bit sums) is read once per pixel and
// needs no clearing after reset. Write frame size registers only while the block
// is idle.

module bgra_to_nv12_converter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bnv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bnv_pkg::CFG_W-1:0]       cfg_wdata,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bnv_pkg::IN_DATA_W-1:0]   s_tdata,   // blue_in, green_in, red_in
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bnv_pkg::OUT_DATA_W-1:0]  m_tdata,   // sample_first, sample_second
    output logic                            m_tlast,   // last_of_item
    output logic [bnv_pkg::OUT_USER_W-1:0]  m_tuser    // out_kind, frame_done
);

    import bnv_pkg::*;

    logic                 s1_valid;
    logic                 s1_adv;
    logic [IN_DATA_W-1:0] s1_pix;
    pix_ctl_t             s1_ctl;
    logic [7:0]           s1_luma;
    logic [7:0]           s1_cb;
    logic [7:0]           s1_cr;
    logic [LINE_W-1:0]    line_rd_data;
    logic                 line_wr_en;
    logic [SLOT_W-1:0]    line_wr_addr;
    logic [LINE_W-1:0]    line_wr_data;

    // Configuration, positions and stage 1
    bnv_input_stage u_input (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s1_adv    (s1_adv),
        .s1_valid  (s1_valid),
        .s1_pix    (s1_pix),
        .s1_ctl    (s1_ctl)
    );

    // Color conversion of the stage 1 pixel
    bnv_csc u_csc (
        .pix  (s1_pix),
        .luma (s1_luma),
        .cb   (s1_cb),
        .cr   (s1_cr)
    );

    // Chroma line store, read as the pixel moves into stage 2
    bnv_line_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (s1_adv),
        .rd_addr (s1_ctl.slot),
        .rd_data (line_rd_data)
    );

    // Stage 2 and output register
    bnv_chroma_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ctl       (s1_ctl),
        .s1_luma      (s1_luma),
        .s1_cb        (s1_cb),
        .s1_cr        (s1_cr),
        .s1_adv       (s1_adv),
        .line_rd_data (line_rd_data),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

FILE: sv/bnv_port_checker.sv
// Port-level checks of the converter output stream, bound to the top level.
// Depends on bnv_pkg and bgra_to_nv12_converter_core.

module bnv_port_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bnv_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic [bnv_pkg::OUT_USER_W-1:0] m_tuser
);

    import bnv_pkg::*;

    // A luma that is not the last of its pixel is followed at once by the chroma pair
    a_chroma_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser[0] == KIND_LUMA) && !m_tlast
        |=> m_tvalid && (m_tuser[0] == KIND_CHROMA))
        else $error("chroma pair did not follow its luma");

    // Luma transactions carry a zero second sample
    a_luma_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == KIND_LUMA) |-> (m_tdata[15:8] == 8'd0))
        else $error("luma transaction with nonzero second sample");

    // Frame end only on the final transaction of a pixel
    a_frame_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("frame end flagged on a non-final transaction");

    // Stalled output holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready
        |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output payload changed while stalled");

endmodule

bind bgra_to_nv12_converter_core bnv_port_checker u_port_checker (.*);

FILE: tb/nv12_stream_checker.sv
// Scoreboard for the BGRA to NV12 converter: watches the pixel, result and
// register-write channels, predicts every result transaction and compares it.
// Depends on bnv_pkg.

module nv12_stream_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bnv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bnv_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bnv_pkg::IN_DATA_W-1:0]  s_tdata,   // blue_in, green_in, red_in
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bnv_pkg::OUT_DATA_W-1:0] m_tdata,   // sample_first, sample_second
    input  logic                           m_tlast,   // last_of_item
    input  logic [bnv_pkg::OUT_USER_W-1:0] m_tuser,   // out_kind, frame_done
    output int                             samples_owed,
    output int                             mismatches
);

    import bnv_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] first;
        logic [7:0] second;
        logic       last;
        logic       done;
    } nv12_sample_t;

    nv12_sample_t      awaited_samples[$];
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_pos;
    logic [ROW_W-1:0]  row_pos;
    logic [7:0]        held_u;
    logic [7:0]        held_v;
    logic [LANE_W-1:0] u_sum_line [LINE_DEPTH];
    logic [LANE_W-1:0] v_sum_line [LINE_DEPTH];

    // Frame dimension in use: low bit dropped, held within 2..limit
    function automatic int usable_size(logic [CFG_W-1:0] raw, int limit);
        int v;
        v = int'(raw) & ~1;
        if (v < 2)
            v = 2;
        if (v > limit)
            v = limit;
        return v;
    endfunction

    // Weighted sum of the components, rounded, floored by 256, offset, clamped
    function automatic logic [7:0] weigh(int kr, int kg, int kb, int base,
                                         logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int acc;
        acc = kr * int'(r) + kg * int'(g) + kb * int'(b) + 128;
        acc = (acc >>> 8) + base;
        if (acc < 0)
            return 8'd0;
        if (acc > 255)
            return 8'd255;
        return acc[7:0];
    endfunction

    task automatic report(string msg);
        mismatches++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Expected results of one accepted pixel
    task automatic convert_pixel(logic [IN_DATA_W-1:0] px);
        logic [7:0]        b;
        logic [7:0]        g;
        logic [7:0]        r;
        logic [7:0]        y;
        logic [7:0]        u;
        logic [7:0]        v;
        logic [SLOT_W-1:0] slot;
        logic              row_end;
        logic              frame_end;
        int                w;
        int                h;
        int                su;
        int                sv;
        b = px[7:0];
        g = px[15:8];
        r = px[23:16];
        w = usable_size(width_reg, MAX_WIDTH);
        h = usable_size(height_reg, MAX_HEIGHT);
        y = weigh(66, 129, 25, 16, r, g, b);
        u = weigh(-38, -74, 112, 128, r, g, b);
        v = weigh(112, -94, -18, 128, r, g, b);
        slot = col_pos[COL_W-1:1];
        row_end = (int'(col_pos) + 1 >= w);
        frame_end = row_end && (int'(row_pos) + 1 >= h);

        if (!col_pos[0])
        begin
            held_u = u;
            held_v = v;
        end

        if (col_pos[0] && row_pos[0])
        begin
            // odd row, odd column: luma, then the averaged 2x2 chroma pair
            su = int'(u_sum_line[slot]) + int'(held_u) + int'(u) + 2;
            sv = int'(v_sum_line[slot]) + int'(held_v) + int'(v) + 2;
            awaited_samples.push_back('{KIND_LUMA, y, 8'd0, 1'b0, 1'b0});
            awaited_samples.push_back('{KIND_CHROMA, 8'(su / 4), 8'(sv / 4), 1'b1,
                                        frame_end});
        end
        else
        begin
            if (col_pos[0])
            begin
                u_sum_line[slot] = {1'b0, held_u} + {1'b0, u};
                v_sum_line[slot] = {1'b0, held_v} + {1'b0, v};
            end
            awaited_samples.push_back('{KIND_LUMA, y, 8'd0, 1'b1, frame_end});
        end

        // raster position of the next pixel
        if (row_end)
        begin
            col_pos = '0;
            row_pos = frame_end ? '0 : row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_sample();
        nv12_sample_t want;
        if (awaited_samples.size() == 0)
        begin
            report($sformatf("unexpected result transaction, tdata %h tuser %b",
                             m_tdata, m_tuser));
            return;
        end
        want = awaited_samples.pop_front();
        if (m_tuser[0] !== want.kind)
            report($sformatf("out_kind %b, expected %b", m_tuser[0], want.kind));
        if (m_tdata[7:0] !== want.first)
            report($sformatf("sample_first %0d, expected %0d", m_tdata[7:0], want.first));
        if (m_tdata[15:8] !== want.second)
            report($sformatf("sample_second %0d, expected %0d", m_tdata[15:8], want.second));
        if (m_tlast !== want.last)
            report($sformatf("last_of_item %b, expected %b", m_tlast, want.last));
        if (m_tuser[1] !== want.done)
            report($sformatf("frame_done %b, expected %b", m_tuser[1], want.done));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            col_pos    = '0;
            row_pos    = '0;
            held_u     = '0;
            held_v     = '0;
            mismatches = 0;
            awaited_samples.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:  width_reg  = cfg_wdata;
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_sample();
            if (s_tvalid && s_tready)
                convert_pixel(s_tdata);
        end
        samples_owed = awaited_samples.size();
    end

endmodule

FILE: tb/bgra_to_nv12_converter_core_tb.sv
// Testbench top for the BGRA to NV12 converter: clock, reset, pixel stimulus,
// register writes, output back-pressure and the verdict.
// Depends on bnv_pkg, bgra_to_nv12_converter_core and nv12_stream_checker.

module bgra_to_nv12_converter_core_tb;
    import bnv_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 1100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;

    int   samples_owed;
    int   mismatches;
    int   stall_cycles = 0;
    logic steady;

    // stimulus-side view of the raster position and frame size
    int col_at;
    int row_at;
    int width_now;
    int height_now;
    int swatch_idx;
    int pixels_sent;
    int directed_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    bgra_to_nv12_converter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    nv12_stream_checker CHK (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .samples_owed (samples_owed),
        .mismatches   (mismatches)
    );

    // Output back-pressure: about one stall cycle in ten, none while steady
    always @(negedge clk)
        m_tready <= rst_n && (steady || $urandom_range(99) >= 10);

    // Watchdog: cycles in a row with no transaction on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("Verification failed");
        $finish;
    end

    function automatic int dim_of(logic [CFG_W-1:0] raw, int limit);
        int v;
        v = int'(raw) & ~1;
        if (v < 2)
            v = 2;
        if (v > limit)
            v = limit;
        return v;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_now = dim_of(val, MAX_WIDTH);
        else
            height_now = dim_of(val, MAX_HEIGHT);
    endtask

    // Hold off pixels until every owed result is out and the pipe is empty
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (samples_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_pixel(logic [IN_DATA_W-1:0] px);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
        if (col_at + 1 >= width_now)
        begin
            col_at = 0;
            row_at = (row_at + 1 >= height_now) ? 0 : row_at + 1;
        end
        else
            col_at++;
        pixels_sent++;
    endtask

    // n pixels, either from the fixed color set or fully random
    task automatic send_run(int n, bit from_swatches);
        logic [IN_DATA_W-1:0] px;
        for (int i = 0; i < n; i++)
        begin
            if (from_swatches)
            begin
                case (swatch_idx % 10)       // {red, green, blue}
                    0: px = 24'h000000;
                    1: px = 24'hFFFFFF;
                    2: px = 24'hFF0000;
                    3: px = 24'h00FF00;
                    4: px = 24'h0000FF;
                    5: px = 24'hFFFF00;
                    6: px = 24'h00FFFF;
                    7: px = 24'hFF00FF;
                    8: px = 24'h808080;
                    default: px = 24'h7F7F7F;
                endcase
                swatch_idx++;
            end
            else
                px = IN_DATA_W'($urandom);
            send_pixel(px);
        end
    endtask

    // Width may grow only at the start of an even row, so that an odd row
    // never reads a line entry that no even row has filled
    function automatic logic [CFG_W-1:0] pick_width();
        int r;
        int hi;
        r = $urandom_range(99);
        if (col_at == 0 && row_at % 2 == 0)
        begin
            if (r < 6)
                return CFG_W'($urandom_range(1));
            if (r < 10)
                return CFG_W'($urandom_range(4097, 8191));
            return CFG_W'($urandom_range(2, 18));
        end
        hi = (r < 50 && width_now > 17) ? 17 : width_now + 1;
        return CFG_W'($urandom_range(0, hi));
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return CFG_W'($urandom_range(1));
        if (r < 10)
            return CFG_W'($urandom_range(4097, 8191));
        if (r < 15)
            return CFG_W'($urandom);
        return CFG_W'($urandom_range(2, 10));
    endfunction

    initial
    begin : stimulus
        int remaining;
        int n;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_FRAME_WIDTH;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        steady      = 1'b0;
        col_at      = 0;
        row_at      = 0;
        width_now   = dim_of(FRAME_WIDTH_RST, MAX_WIDTH);
        height_now  = dim_of(FRAME_HEIGHT_RST, MAX_HEIGHT);
        swatch_idx  = 0;
        pixels_sent = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset frame size, then shrink mid-row down to the tiny 2x2 size
        send_run(6, 1);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(1));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
        send_run(3, 1);

        // Odd register values: low bit dropped, one whole 4x2 frame
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(5));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        send_run(8, 1);

        // Oversize clamps, then a mid-frame shrink of width and height
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(8191));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(8191));
        send_run(4, 1);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        send_run(3, 1);
        settle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
        directed_count = pixels_sent;

        // Random runs, mostly whole small frames, with size changes in between
        while (pixels_sent < directed_count + RANDOM_PIXELS)
        begin
            steady = (pixels_sent >= directed_count + 400) &&
                     (pixels_sent < directed_count + 650);
            if ($urandom_range(99) < 30)
            begin
                settle();
                if ($urandom_range(1) != 0)
                    write_reg(REG_FRAME_WIDTH, pick_width());
                if ($urandom_range(2) != 0)
                    write_reg(REG_FRAME_HEIGHT, pick_height());
            end
            remaining = (height_now - row_at) * width_now - col_at;
            if (remaining <= 48 && $urandom_range(3) != 0)
                n = remaining;
            else
                n = $urandom_range(1, 40);
            send_run(n, 0);
        end

        // Drain and give the verdict
        steady = 1'b0;
        settle();
        if (mismatches == 0 && samples_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: bgra_to_nv12_converter_core.f
sv/bnv_pkg.sv
sv/bnv_line_ram.sv
sv/bnv_input_stage.sv
sv/bnv_csc.sv
sv/bnv_chroma_out.sv
sv/bgra_to_nv12_converter_core.sv
sv/bnv_port_checker.sv
tb/nv12_stream_checker.sv
tb/bgra_to_nv12_converter_core_tb.sv
